// File: rtl/core/pli_pkg.sv
// ----------------------------------------------------------------------------
// Positional list package
// Shared codes and types for the positional list and its storage cells.
// ----------------------------------------------------------------------------
package pli_pkg;

  // Field widths of the request and result transfers.
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 5;

  // Request codes.
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DUMP   = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd3;

  // Operation broadcast along the row of cells.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

endpackage

// File: rtl/core/pli_cell.sv
// ----------------------------------------------------------------------------
// Positional list storage cell
// Holds one list entry and moves data to or from its neighbours.
// ----------------------------------------------------------------------------
module pli_cell #(
  parameter int unsigned IdxW  = 4,
  parameter int unsigned Index = 0
) (
  input  logic                       clk_i,
  input  pli_pkg::cell_op_e          op_i,
  input  logic [IdxW-1:0]            pos_idx_i,
  input  logic [IdxW-1:0]            tail_idx_i,
  input  logic [pli_pkg::DATA_W-1:0] value_i,
  input  logic [pli_pkg::DATA_W-1:0] left_i,
  input  logic [pli_pkg::DATA_W-1:0] right_i,
  input  logic [pli_pkg::DATA_W-1:0] head_i,
  output logic [pli_pkg::DATA_W-1:0] data_o
);
  import pli_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Index);

  logic [DATA_W-1:0] data_d, data_q;

  // Select the new entry from the broadcast operation and this cell's place.
  always_comb begin
    data_d = data_q;
    case (op_i)
      CELL_INSERT: begin
        if (MyIdx == pos_idx_i) begin
          data_d = value_i;
        end else if (MyIdx > pos_idx_i) begin
          data_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (MyIdx >= pos_idx_i) begin
          data_d = right_i;
        end
      end
      CELL_ROTATE: begin
        if (MyIdx == tail_idx_i) begin
          data_d = head_i;
        end else if (MyIdx < tail_idx_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // Entry storage needs no reset: only written entries are ever read.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: rtl/core/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Positional list with insert and delete at position
// Bounded ordered list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Usage: a request transfer carries action, position and value. Insert and
// delete use 1-based positions; each gives one result in the cycle after the
// request is taken, with status, the new length and last set. A dump gives
// one result per entry in order, one per cycle while the output is not
// stalled, with last on the final one; a dump of an empty list gives a
// single result with status empty. Every cell shifts in the same cycle.
// A dump rotates the occupied cells one place per cycle while the output
// is not stalled and reads the head cell; the list ends in original order.
// Action code 3 is taken and ignored.
// A request is taken in the cycle the previous result is transferred, so
// unstalled inserts and deletes follow back to back; a stalled result holds
// and stalls further requests until it is taken.
// Reset empties the list; entry storage itself is not cleared.
// ----------------------------------------------------------------------------
module positional_list_insert_delete #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [pli_pkg::ACT_W-1:0]  action_i,
  input  logic [pli_pkg::POS_W-1:0]  position_i,
  input  logic signed [pli_pkg::DATA_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pli_pkg::STAT_W-1:0] status_o,
  output logic signed [pli_pkg::DATA_W-1:0] item_o,
  output logic [pli_pkg::LEN_W-1:0]  length_o,
  output logic                       last_o
);
  import pli_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = ((CntW > POS_W) ? CntW : POS_W) + 1;

  // Sequencer and list length.
  state_e            state_d, state_q;
  logic [CntW-1:0]   count_d, count_q;
  logic [CntW-1:0]   dump_idx_d, dump_idx_q;

  // Result register.
  logic              out_valid_d, out_valid_q;
  logic [STAT_W-1:0] status_d, status_q;
  logic [DATA_W-1:0] item_d, item_q;
  logic [LEN_W-1:0]  length_d, length_q;
  logic              last_d, last_q;

  // Cell row.
  cell_op_e          cell_op;
  logic [IdxW-1:0]   pos_idx, tail_idx;
  logic [DATA_W-1:0] cell_data [DEPTH];

  logic              out_free, in_xfer;
  logic [CmpW-1:0]   pos_ext, cnt_ext;
  logic              ins_ok, del_ok, full, dump_end;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Position checks.
  assign pos_ext  = CmpW'(position_i);
  assign cnt_ext  = CmpW'(count_q);
  assign ins_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext + CmpW'(1));
  assign del_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign full     = (count_q == CntW'(DEPTH));
  assign pos_idx  = IdxW'(position_i - POS_W'(1));
  assign tail_idx = IdxW'(count_q - CntW'(1));
  assign dump_end = (dump_idx_q == count_q - CntW'(1));

  // Request decode, dump sequencing and result formation.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dump_idx_d  = dump_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    item_d      = item_q;
    length_d    = length_q;
    last_d      = last_q;
    cell_op     = CELL_HOLD;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          item_d = '0;
          last_d = 1'b1;
          case (action_i)
            ACT_INSERT: begin
              out_valid_d = 1'b1;
              if (!ins_ok) begin
                status_d = STAT_BAD_POS;
              end else if (full) begin
                status_d = STAT_FULL;
              end else begin
                status_d = STAT_OK;
                cell_op  = CELL_INSERT;
                count_d  = count_q + CntW'(1);
              end
            end
            ACT_DELETE: begin
              out_valid_d = 1'b1;
              if (!del_ok) begin
                status_d = STAT_BAD_POS;
              end else begin
                status_d = STAT_OK;
                cell_op  = CELL_DELETE;
                count_d  = count_q - CntW'(1);
              end
            end
            ACT_DUMP: begin
              out_valid_d = 1'b1;
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                // First entry goes out now; the rest follow one per cycle while the output is not stalled.
                status_d = STAT_OK;
                item_d   = cell_data[0];
                cell_op  = CELL_ROTATE;
                last_d   = (count_q == CntW'(1));
                if (count_q != CntW'(1)) begin
                  dump_idx_d = CntW'(1);
                  state_d    = ST_DUMP;
                end
              end
            end
            default: out_valid_d = out_valid_q && out_stall_i;
          endcase
          length_d = LEN_W'(count_d);
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = STAT_OK;
          item_d      = cell_data[0];
          length_d    = LEN_W'(count_q);
          last_d      = dump_end;
          cell_op     = CELL_ROTATE;
          dump_idx_d  = dump_idx_q + CntW'(1);
          if (dump_end) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dump_idx_q  <= dump_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    item_q   <= item_d;
    length_q <= length_d;
    last_q   <= last_d;
  end

  // Row of storage cells; end cells take their own entry as missing neighbour.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    pli_cell #(
      .IdxW  (IdxW),
      .Index (k)
    ) u_cell (
      .clk_i      (clk_i),
      .op_i       (cell_op),
      .pos_idx_i  (pos_idx),
      .tail_idx_i (tail_idx),
      .value_i    (value_i),
      .left_i     (cell_data[(k > 0) ? k - 1 : k]),
      .right_i    (cell_data[(k < DEPTH - 1) ? k + 1 : k]),
      .head_i     (cell_data[0]),
      .data_o     (cell_data[k])
    );
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign item_o      = item_q;
  assign length_o    = length_q;
  assign last_o      = last_q;

endmodule
